@@ hdl/lru_page_cache_directory_top_macros.svh @@
// Assertion macros used by the directory RTL.
`ifndef LRU_PAGE_CACHE_DIRECTORY_TOP_MACROS_SVH
`define LRU_PAGE_CACHE_DIRECTORY_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPCD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lpcd_pkg.sv @@
// Types and constants of the LRU page cache directory.
`timescale 1ns / 1ps
package lpcd_pkg;

   localparam int CAPACITY   = 16;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int TAG_W      = 64;
   localparam int TOTAL_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CAP_W      = 5;

   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      KIND_LOOKUP     = 2'd0,
      KIND_PUT        = 2'd1,
      KIND_INVALIDATE = 2'd2,
      KIND_CLEAR      = 2'd3
   } kind_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               slot_valid;
      logic               evicted;
      logic [TAG_W-1:0]   evicted_offset;
      logic [COUNT_W-1:0] occupancy;
      logic [TOTAL_W-1:0] hit_total;
      logic [TOTAL_W-1:0] miss_total;
   } rsp_type;

endpackage

@@ hdl/lpcd_req_if.sv @@
// Request channel: kind and page offset with valid/ready.
`timescale 1ns / 1ps
interface lpcd_req_if;
   import lpcd_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [TAG_W-1:0]    page_offset;

   modport source (output valid, output kind, output page_offset, input ready);
   modport sink   (input valid, input kind, input page_offset, output ready);
endinterface

@@ hdl/lpcd_rsp_if.sv @@
// Response channel: lookup and update results with valid/ready.
`timescale 1ns / 1ps
interface lpcd_rsp_if;
   import lpcd_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [SLOT_W-1:0]   slot;
   logic                slot_valid;
   logic                evicted;
   logic [TAG_W-1:0]    evicted_offset;
   logic [COUNT_W-1:0]  occupancy;
   logic [TOTAL_W-1:0]  hit_total;
   logic [TOTAL_W-1:0]  miss_total;

   modport source (output valid, output hit, output slot, output slot_valid,
                   output evicted, output evicted_offset, output occupancy,
                   output hit_total, output miss_total, input ready);
   modport sink   (input valid, input hit, input slot, input slot_valid,
                   input evicted, input evicted_offset, input occupancy,
                   input hit_total, input miss_total, output ready);
endinterface

@@ hdl/lpcd_dir.sv @@
// Directory state: tag CAM, recency ranks, occupancy and hit/miss counters.
`timescale 1ns / 1ps
`include "lru_page_cache_directory_top_macros.svh"
module lpcd_dir (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  lpcd_pkg::kind_type         kind,
   input  logic [lpcd_pkg::TAG_W-1:0] tag,
   input  logic [lpcd_pkg::CAP_W-1:0] capacity,
   output lpcd_pkg::rsp_type          res
);
   import lpcd_pkg::*;

   logic [CAPACITY-1:0]            valid_ff, valid_in;
   logic [TAG_W-1:0]               tag_ff  [CAPACITY];
   logic [SLOT_W-1:0]              rank_ff [CAPACITY];
   logic [SLOT_W-1:0]              rank_in [CAPACITY];
   logic [COUNT_W-1:0]             live_ff, live_in;
   logic [TOTAL_W-1:0]             hits_ff, hits_in;
   logic [TOTAL_W-1:0]             miss_ff, miss_in;

   logic [CAPACITY-1:0]            match;
   logic                           found;
   logic [SLOT_W-1:0]              found_idx;
   logic [SLOT_W-1:0]              found_rank;
   logic [SLOT_W-1:0]              lru_idx;
   logic [SLOT_W-1:0]              lru_rank;
   logic [SLOT_W-1:0]              free_idx;
   logic [COUNT_W-1:0]             cap_eff;
   logic                           full;
   logic                           insert;
   logic [SLOT_W-1:0]              place;

   assign cap_eff  = (capacity > CAP_W'(CAPACITY)) ? COUNT_W'(CAPACITY)
                                                   : COUNT_W'(capacity);
   assign full     = live_ff >= cap_eff;
   assign lru_rank = SLOT_W'(live_ff - COUNT_W'(1));

   // parallel compares; ranks of live entries are distinct
   always_comb begin
      found_idx = '0;
      found_rank = '0;
      lru_idx = '0;
      free_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == tag);
         found_idx  = found_idx  | (match[i] ? SLOT_W'(i) : '0);
         found_rank = found_rank | (match[i] ? rank_ff[i] : '0);
         lru_idx = lru_idx |
                   ((valid_ff[i] && rank_ff[i] == lru_rank) ? SLOT_W'(i) : '0);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign found  = |match;
   assign insert = (kind == KIND_PUT) && !found && (cap_eff != '0);
   assign place  = full ? lru_idx : free_idx;

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      live_in  = live_ff;
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      res = '0;
      unique case (kind)
         KIND_LOOKUP: begin
            if (found) begin
               hits_in = hits_ff + TOTAL_W'(1);
               res.hit = 1'b1;
               res.slot = found_idx;
               res.slot_valid = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid_ff[i] && rank_ff[i] < found_rank) begin
                     rank_in[i] = rank_ff[i] + SLOT_W'(1);
                  end
               end
               rank_in[found_idx] = '0;
            end else begin
               miss_in = miss_ff + TOTAL_W'(1);
            end
         end
         KIND_PUT: begin
            if (found) begin
               res.hit = 1'b1;
               res.slot = found_idx;
               res.slot_valid = 1'b1;
               if (cap_eff != '0) begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (valid_ff[i] && rank_ff[i] < found_rank) begin
                        rank_in[i] = rank_ff[i] + SLOT_W'(1);
                     end
                  end
                  rank_in[found_idx] = '0;
               end
            end else if (insert) begin
               // every live entry ages by one; an evicted entry held the top rank and is overwritten
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + SLOT_W'(1);
                  end
               end
               valid_in[place] = 1'b1;
               rank_in[place] = '0;
               live_in = full ? live_ff : live_ff + COUNT_W'(1);
               res.slot = place;
               res.slot_valid = 1'b1;
               res.evicted = full;
               res.evicted_offset = full ? tag_ff[lru_idx] : '0;
            end
         end
         KIND_INVALIDATE: begin
            if (found) begin
               res.hit = 1'b1;
               res.slot = found_idx;
               valid_in[found_idx] = 1'b0;
               live_in = live_ff - COUNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid_ff[i] && rank_ff[i] > found_rank) begin
                     rank_in[i] = rank_ff[i] - SLOT_W'(1);
                  end
               end
            end
         end
         KIND_CLEAR: begin
            valid_in = '0;
            live_in = '0;
         end
         default: begin
         end
      endcase
      res.occupancy  = live_in;
      res.hit_total  = hits_in;
      res.miss_total = miss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
      end else if (step) begin
         valid_ff <= valid_in;
         live_ff <= live_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rank_ff <= rank_in;
         if (insert) begin
            tag_ff[place] <= tag;
         end
      end
   end

   `LPCD_ASSERT_NOW(a_live_count, clock, reset, 1'b1, $countones(valid_ff) == int'(live_ff), "occupancy does not match valid entries")
   `LPCD_ASSERT_NEXT(a_clear_empty, clock, reset, step && kind == KIND_CLEAR, valid_ff == '0 && live_ff == '0, "clear left live entries")
   `LPCD_ASSERT_NOW(a_evict_put_miss, clock, reset, step && res.evicted, kind == KIND_PUT && !res.hit && full, "eviction outside a put miss at capacity")
   `LPCD_ASSERT_NOW(a_slot_live, clock, reset, step && res.slot_valid, valid_in[res.slot], "reported slot is not live")

endmodule

@@ hdl/lru_page_cache_directory_top.sv @@
// Top level of the LRU page cache directory: channels, capacity register, pipeline.
//
//   channel | dir | contents
//   req_ch  | in  | kind, page_offset
//   rsp_ch  | out | hit, slot, slot_valid, evicted, evicted_offset, occupancy, totals
//   csr_*   | cfg | active_capacity at byte address 0
//
// One word per cycle sustained while responses are taken; a request passes the request
// register, then the response register, with the tag compare and rank update between them.
// Synchronous reset empties the directory and zeroes counters; capacity resets to 16.
// A stalled response holds; a request is taken while the request register is empty or the response register frees.
`timescale 1ns / 1ps
module lru_page_cache_directory_top (
   input  logic                            clock,
   input  logic                            reset,
   lpcd_req_if.sink                        req_ch,
   lpcd_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lpcd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lpcd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lpcd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lpcd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   kind_type           in_kind_ff;
   logic [TAG_W-1:0]   in_tag_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff;
   rsp_type            res;
   logic [CAP_W-1:0]   cap_ff;
   logic               out_free;
   logic               step;
   logic               req_fire;
   logic               csr_write;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_ch.kind;
         in_tag_ff <= req_ch.page_offset;
      end
      if (step) begin
         out_ff <= res;
      end
   end

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == CSR_IDX_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAPACITY)
                       ? {{(CSR_DATA_W-CAP_W){1'b0}}, cap_ff} : '0;

   lpcd_dir u_dir (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .kind     (in_kind_ff),
      .tag      (in_tag_ff),
      .capacity (cap_ff),
      .res      (res)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.hit            = out_ff.hit;
   assign rsp_ch.slot           = out_ff.slot;
   assign rsp_ch.slot_valid     = out_ff.slot_valid;
   assign rsp_ch.evicted        = out_ff.evicted;
   assign rsp_ch.evicted_offset = out_ff.evicted_offset;
   assign rsp_ch.occupancy      = out_ff.occupancy;
   assign rsp_ch.hit_total      = out_ff.hit_total;
   assign rsp_ch.miss_total     = out_ff.miss_total;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the LRU page cache directory: directed and random traffic against a directory model.
`timescale 1ns / 1ps
module tb_top;
   import lpcd_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int POOL_N = 24;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * CSR_IDX_CAPACITY);

   class directory_scoreboard;
      bit                ent_live[CAPACITY];
      logic [TAG_W-1:0]  ent_tag[CAPACITY];
      int unsigned       ent_rank[CAPACITY];
      int unsigned       live;
      bit [TOTAL_W-1:0]  hits;
      bit [TOTAL_W-1:0]  misses;
      bit [CAP_W-1:0]    cap_reg;
      rsp_type           pending[$];
      int                errors;

      function new();
         foreach (ent_live[i]) begin
            ent_live[i] = 0;
            ent_tag[i] = '0;
            ent_rank[i] = 0;
         end
         live = 0;
         hits = '0;
         misses = '0;
         cap_reg = CAP_RESET;
         errors = 0;
      endfunction

      function void set_capacity(logic [CSR_DATA_W-1:0] value);
         cap_reg = value[CAP_W-1:0];
      endfunction

      function int find_tag(logic [TAG_W-1:0] tag);
         for (int i = 0; i < CAPACITY; i++)
            if (ent_live[i] && ent_tag[i] === tag) return i;
         return -1;
      endfunction

      function void promote(int s);
         int unsigned r;
         r = ent_rank[s];
         for (int i = 0; i < CAPACITY; i++)
            if (ent_live[i] && ent_rank[i] < r) ent_rank[i]++;
         ent_rank[s] = 0;
      endfunction

      function void drop(int s);
         int unsigned r;
         r = ent_rank[s];
         ent_live[s] = 0;
         for (int i = 0; i < CAPACITY; i++)
            if (ent_live[i] && ent_rank[i] > r) ent_rank[i]--;
         if (live > 0) live--;
      endfunction

      function void note_request(kind_type k, logic [TAG_W-1:0] tag);
         rsp_type     r;
         int          s;
         int          place;
         int          lru;
         int unsigned cap;
         cap = (cap_reg > CAPACITY) ? CAPACITY : cap_reg;
         r = '0;
         s = -1;
         if (k != KIND_CLEAR) s = find_tag(tag);
         case (k)
            KIND_LOOKUP: begin
               if (s >= 0) begin
                  r.hit = 1;
                  r.slot = SLOT_W'(s);
                  r.slot_valid = 1;
                  hits++;
                  promote(s);
               end else begin
                  misses++;
               end
            end
            KIND_PUT: begin
               if (s >= 0) begin
                  r.hit = 1;
                  r.slot = SLOT_W'(s);
                  r.slot_valid = 1;
                  if (cap != 0) promote(s);
               end else if (cap != 0) begin
                  place = -1;
                  if (live >= cap) begin
                     lru = -1;
                     for (int i = 0; i < CAPACITY; i++)
                        if (ent_live[i] && (lru < 0 || ent_rank[i] > ent_rank[lru])) lru = i;
                     if (lru >= 0) begin
                        r.evicted = 1;
                        r.evicted_offset = ent_tag[lru];
                        drop(lru);
                        place = lru;
                     end
                  end
                  if (place < 0)
                     for (int i = 0; i < CAPACITY; i++)
                        if (!ent_live[i]) begin
                           place = i;
                           break;
                        end
                  if (place >= 0) begin
                     for (int i = 0; i < CAPACITY; i++)
                        if (ent_live[i]) ent_rank[i]++;
                     ent_live[place] = 1;
                     ent_tag[place] = tag;
                     ent_rank[place] = 0;
                     live++;
                     r.slot = SLOT_W'(place);
                     r.slot_valid = 1;
                  end
               end
            end
            KIND_INVALIDATE: begin
               if (s >= 0) begin
                  r.hit = 1;
                  r.slot = SLOT_W'(s);
                  drop(s);
               end
            end
            default: begin
               foreach (ent_live[i]) ent_live[i] = 0;
               live = 0;
            end
         endcase
         r.occupancy = COUNT_W'(live);
         r.hit_total = hits;
         r.miss_total = misses;
         pending = {pending, r};
      endfunction

      function void compare_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("response word with nothing outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("hit", TAG_W'(want.hit), TAG_W'(got.hit));
         compare_field("slot", TAG_W'(want.slot), TAG_W'(got.slot));
         compare_field("slot_valid", TAG_W'(want.slot_valid), TAG_W'(got.slot_valid));
         compare_field("evicted", TAG_W'(want.evicted), TAG_W'(got.evicted));
         compare_field("evicted_offset", want.evicted_offset, got.evicted_offset);
         compare_field("occupancy", TAG_W'(want.occupancy), TAG_W'(got.occupancy));
         compare_field("hit_total", TAG_W'(want.hit_total), TAG_W'(got.hit_total));
         compare_field("miss_total", TAG_W'(want.miss_total), TAG_W'(got.miss_total));
      endfunction

      function void check_leftover();
         if (pending.size() != 0) begin
            $error("%0d responses never arrived", pending.size());
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lpcd_req_if req_ch();
   lpcd_rsp_if rsp_ch();

   directory_scoreboard sb;
   rsp_type             got;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  stall_cycles;
   logic [TAG_W-1:0]    tag_pool[POOL_N];

   lru_page_cache_directory_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response check first, then the new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.hit = rsp_ch.hit;
            got.slot = rsp_ch.slot;
            got.slot_valid = rsp_ch.slot_valid;
            got.evicted = rsp_ch.evicted;
            got.evicted_offset = rsp_ch.evicted_offset;
            got.occupancy = rsp_ch.occupancy;
            got.hit_total = rsp_ch.hit_total;
            got.miss_total = rsp_ch.miss_total;
            sb.check_response(got);
         end
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.kind, req_ch.page_offset);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays up for back-to-back words
   task automatic send_word(kind_type k, logic [TAG_W-1:0] offset);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.page_offset <= offset;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CAP_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_capacity(value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_traffic(int count, int pool_span);
      int               pick;
      kind_type         k;
      logic [TAG_W-1:0] tag;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained();
         pick = $urandom_range(99);
         if (pick < 42) k = KIND_LOOKUP;
         else if (pick < 80) k = KIND_PUT;
         else if (pick < 97) k = KIND_INVALIDATE;
         else k = KIND_CLEAR;
         if ($urandom_range(9) == 0) tag = {$urandom, $urandom};
         else tag = tag_pool[$urandom_range(pool_span - 1)];
         send_word(k, tag);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_LOOKUP;
      req_ch.page_offset = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stall_cycles = 0;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) tag_pool[i] = {$urandom, $urandom};
      send_idle_pct = 38;
      recv_idle_pct = 83;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: misses on empty, refresh, drop, lowest free slot, clear
      send_word(KIND_LOOKUP, '0);
      send_word(KIND_INVALIDATE, '1);
      send_word(KIND_PUT, '0);
      send_word(KIND_PUT, '1);
      send_word(KIND_PUT, '0);
      send_word(KIND_LOOKUP, '1);
      send_word(KIND_INVALIDATE, '0);
      send_word(KIND_PUT, 64'h8000_0000_0000_0001);
      send_word(KIND_CLEAR, '1);
      send_word(KIND_LOOKUP, '1);
      for (int i = 2; i < 8; i++) send_word(KIND_PUT, tag_pool[i]);
      // capacity below occupancy: one eviction per new put
      write_capacity(32'd2);
      send_word(KIND_PUT, 64'h5555_AAAA_5555_AAAA);
      send_word(KIND_LOOKUP, 64'h5555_AAAA_5555_AAAA);
      send_word(KIND_PUT, '1);
      // zero capacity: puts report only
      write_capacity(32'd0);
      send_word(KIND_PUT, 64'h5555_AAAA_5555_AAAA);
      send_word(KIND_PUT, 64'h8000_0000_0000_0001);
      send_word(KIND_INVALIDATE, 64'h5555_AAAA_5555_AAAA);
      // above the directory size: saturates
      write_capacity(32'd31);
      send_word(KIND_PUT, 64'h8000_0000_0000_0001);
      send_word(KIND_LOOKUP, 64'h8000_0000_0000_0001);

      write_capacity(32'd16);
      run_traffic(200, POOL_N);
      write_capacity(32'd4);
      run_traffic(200, 7);
      write_capacity(32'd1);
      run_traffic(200, 4);
      send_idle_pct = 83;
      recv_idle_pct = 38;
      write_capacity(32'd0);
      run_traffic(200, 6);
      write_capacity(32'hFFFF_FFFF);
      run_traffic(200, POOL_N);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_capacity(32'd9);
      run_traffic(200, 13);
      write_capacity($urandom);
      run_traffic(200, POOL_N);

      wait_drained();
      sb.check_leftover();
      if (sb.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
